FILE: src/fudec_pkg.sv
package fudec_pkg;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// "file://" is seven characters long
	localparam logic [2:0] PREFIX_LEN = 3'd7;
	localparam logic [3:0] MAX_CNT    = 4'd8;

	typedef enum logic [1:0] {
		MODE_PREFIX = 2'd0,
		MODE_PASS   = 2'd1,
		MODE_DECODE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HEX  = 2'd2
	} esc_t;

	typedef enum logic [1:0] {
		DRV_START  = 2'd0,
		DRV_SLASH  = 2'd1,
		DRV_LETTER = 2'd2,
		DRV_PASS   = 2'd3
	} drv_t;

	typedef logic [7:0][7:0] byte_list_t;

	// all result bytes caused by one input beat
	typedef struct packed {
		byte_list_t bytes;
		logic [3:0] cnt;
		logic       last;
	} rec_t;

	// working copy of the decoder state while one beat is evaluated
	typedef struct packed {
		byte_list_t bytes;
		logic [3:0] cnt;
		esc_t       esc;
		logic [7:0] esc_char;
		drv_t       drv;
		logic [7:0] letter;
	} dec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] prefix_char(logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h66; // f
			3'd1: c = 8'h69; // i
			3'd2: c = 8'h6C; // l
			3'd3: c = 8'h65; // e
			3'd4: c = 8'h3A; // :
			3'd5: c = 8'h2F; // /
			3'd6: c = 8'h2F; // /
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_hex(logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_nibble(logic [7:0] b);
		logic [7:0] t;
		if (b >= 8'h30 && b <= 8'h39) begin
			t = b - 8'h30;
		end else if (b >= 8'h61 && b <= 8'h66) begin
			t = b - 8'h57;
		end else begin
			t = b - 8'h37;
		end
		return t[3:0];
	endfunction

	function automatic logic is_letter(logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
	endfunction

	function automatic dec_t put(dec_t d_in, logic [7:0] b);
		dec_t d;
		d = d_in;
		if (d_in.cnt < MAX_CNT) begin
			d.bytes[d_in.cnt[2:0]] = b;
			d.cnt = d_in.cnt + 4'd1;
		end
		return d;
	endfunction

	// drive letter stage: "/C:" loses its leading slash
	function automatic dec_t drive(dec_t d_in, logic [7:0] b);
		dec_t d;
		d = d_in;
		case (d_in.drv)
			DRV_START: begin
				if (b == CH_SLASH) begin
					d.drv = DRV_SLASH;
				end else begin
					d = put(d, b);
					d.drv = DRV_PASS;
				end
			end
			DRV_SLASH: begin
				if (is_letter(b)) begin
					d.letter = b;
					d.drv = DRV_LETTER;
				end else begin
					d = put(d, CH_SLASH);
					d = put(d, b);
					d.drv = DRV_PASS;
				end
			end
			DRV_LETTER: begin
				if (b != CH_COLON) begin
					d = put(d, CH_SLASH);
				end
				d = put(d, d_in.letter);
				d = put(d, b);
				d.drv = DRV_PASS;
			end
			default: begin
				d = put(d, b);
			end
		endcase
		return d;
	endfunction

	function automatic dec_t plain(dec_t d_in, logic [7:0] b);
		dec_t d;
		d = d_in;
		if (b == CH_PCT) begin
			d.esc = ESC_PCT;
		end else begin
			d = drive(d, b);
		end
		return d;
	endfunction

endpackage

FILE: src/fudec_front.sv
module fudec_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	input  fudec_pkg::q_status_t  q_status,
	output logic                  push,
	output fudec_pkg::rec_t       push_rec
);

	logic [2:0]        pm_q;
	fudec_pkg::mode_t  mode_q;
	fudec_pkg::esc_t   esc_q;
	logic [7:0]        esc_char_q;
	fudec_pkg::drv_t   drv_q;
	logic [7:0]        letter_q;

	logic [2:0]        pm_n;
	fudec_pkg::mode_t  mode_n;
	fudec_pkg::dec_t   d;
	logic              accept;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		d          = '0;
		d.esc      = esc_q;
		d.esc_char = esc_char_q;
		d.drv      = drv_q;
		d.letter   = letter_q;
		pm_n       = pm_q;
		mode_n     = mode_q;

		case (mode_q)
			fudec_pkg::MODE_PREFIX: begin
				if (pm_q < fudec_pkg::PREFIX_LEN && in_byte == fudec_pkg::prefix_char(pm_q)) begin
					pm_n = pm_q + 3'd1;
					if (pm_n == fudec_pkg::PREFIX_LEN) begin
						mode_n = fudec_pkg::MODE_DECODE;
					end else if (in_last) begin
						// short URI: give back the matched part
						for (int k = 0; k < 7; k++) begin
							if (3'(k) < pm_n) begin
								d = fudec_pkg::put(d, fudec_pkg::prefix_char(3'(k)));
							end
						end
					end
				end else begin
					for (int k = 0; k < 7; k++) begin
						if (3'(k) < pm_q) begin
							d = fudec_pkg::put(d, fudec_pkg::prefix_char(3'(k)));
						end
					end
					d = fudec_pkg::put(d, in_byte);
					mode_n = fudec_pkg::MODE_PASS;
				end
			end
			fudec_pkg::MODE_DECODE: begin
				case (esc_q)
					fudec_pkg::ESC_PCT: begin
						if (fudec_pkg::is_hex(in_byte)) begin
							d.esc_char = in_byte;
							d.esc = fudec_pkg::ESC_HEX;
						end else begin
							d = fudec_pkg::drive(d, fudec_pkg::CH_PCT);
							d.esc = fudec_pkg::ESC_NONE;
							d = fudec_pkg::plain(d, in_byte);
						end
					end
					fudec_pkg::ESC_HEX: begin
						if (fudec_pkg::is_hex(in_byte)) begin
							d = fudec_pkg::drive(d, {fudec_pkg::hex_nibble(esc_char_q),
								fudec_pkg::hex_nibble(in_byte)});
							d.esc = fudec_pkg::ESC_NONE;
						end else begin
							d = fudec_pkg::drive(d, fudec_pkg::CH_PCT);
							d = fudec_pkg::drive(d, esc_char_q);
							d.esc = fudec_pkg::ESC_NONE;
							d = fudec_pkg::plain(d, in_byte);
						end
					end
					default: begin
						d.esc = fudec_pkg::ESC_NONE;
						d = fudec_pkg::plain(d, in_byte);
					end
				endcase
			end
			default: begin
				d = fudec_pkg::put(d, in_byte);
			end
		endcase

		if (in_last) begin
			if (mode_n == fudec_pkg::MODE_DECODE) begin
				// flush a pending escape, then held drive bytes
				if (d.esc == fudec_pkg::ESC_PCT) begin
					d = fudec_pkg::drive(d, fudec_pkg::CH_PCT);
				end else if (d.esc == fudec_pkg::ESC_HEX) begin
					d = fudec_pkg::drive(d, fudec_pkg::CH_PCT);
					d = fudec_pkg::drive(d, d.esc_char);
				end
				if (d.drv == fudec_pkg::DRV_SLASH) begin
					d = fudec_pkg::put(d, fudec_pkg::CH_SLASH);
				end else if (d.drv == fudec_pkg::DRV_LETTER) begin
					d = fudec_pkg::put(d, fudec_pkg::CH_SLASH);
					d = fudec_pkg::put(d, d.letter);
				end
			end
			pm_n       = '0;
			mode_n     = fudec_pkg::MODE_PREFIX;
			d.esc      = fudec_pkg::ESC_NONE;
			d.esc_char = '0;
			d.drv      = fudec_pkg::DRV_START;
			d.letter   = '0;
		end
	end

	// beats that make no byte and do not end the URI leave nothing in the queue
	assign push           = accept && (d.cnt != 4'd0 || in_last);
	assign push_rec.bytes = d.bytes;
	assign push_rec.cnt   = d.cnt;
	assign push_rec.last  = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q       <= '0;
			mode_q     <= fudec_pkg::MODE_PREFIX;
			esc_q      <= fudec_pkg::ESC_NONE;
			esc_char_q <= '0;
			drv_q      <= fudec_pkg::DRV_START;
			letter_q   <= '0;
		end else if (accept) begin
			pm_q       <= pm_n;
			mode_q     <= mode_n;
			esc_q      <= d.esc;
			esc_char_q <= d.esc_char;
			drv_q      <= d.drv;
			letter_q   <= d.letter;
		end
	end

endmodule

FILE: src/fudec_queue.sv
module fudec_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fudec_pkg::rec_t       push_rec,
	input  logic                  pop,
	output fudec_pkg::rec_t       pop_rec,
	output fudec_pkg::q_status_t  status
);

	fudec_pkg::rec_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);
	assign pop_rec      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/fudec_back.sv
module fudec_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fudec_pkg::q_status_t  q_status,
	input  fudec_pkg::rec_t       q_rec,
	output logic                  pop,
	output logic                  tvalid,
	input  logic                  tready,
	output logic [7:0]            tdata,
	output logic                  tuser,
	output logic                  tlast
);

	fudec_pkg::rec_t rec_q;
	logic            valid_q;
	logic [2:0]      idx_q;
	logic            last_beat;
	logic            advance;

	// a record with no byte is a bare end marker and takes one beat
	assign last_beat = (rec_q.cnt == 4'd0) || ({1'b0, idx_q} + 4'd1 == rec_q.cnt);
	assign advance   = !valid_q || (tready && last_beat);
	assign pop       = advance && !q_status.empty;

	assign tvalid = valid_q;
	assign tuser  = (rec_q.cnt != 4'd0);
	assign tdata  = tuser ? rec_q.bytes[idx_q] : 8'h00;
	assign tlast  = rec_q.last && last_beat;

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= q_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= !q_status.empty;
			idx_q   <= '0;
		end else if (valid_q && tready) begin
			idx_q <= idx_q + 3'd1;
		end
	end

endmodule

FILE: src/file_uri_to_path_decoder_unit.sv
// file URI to path decoder
//
// Slave stream: one URI byte per beat, tlast on the final byte of each URI.
// Master stream: one path byte per beat. tuser high means tdata carries a byte;
// tuser low is a bare end marker (tdata zero, tlast high), sent only when the
// final input beat leaves no byte to carry tlast (for example "file://" alone).
// Text not starting with "file://" passes through unchanged; otherwise the
// prefix is stripped, %XX escapes are decoded and "/C:" loses its leading slash.
//
// An accepted beat is written into the queue, then into the output register.
// Throughput: one beat per cycle while m_axis_tready is high and each input
// beat makes at most one output beat. A beat that makes N bytes (prefix mismatch,
// malformed escape, drive letter or end-of-URI flush, N up to 7) holds the
// serializer until all N have gone out; the two-entry queue between decoder and
// serializer absorbs that, and s_axis_tready drops only while the queue is full.
// A master-side stall backs up into the queue and then into s_axis_tready;
// no byte is lost or repeated.
// Reset (arst_n low) empties the queue and the output and returns the decoder
// to the start of a URI.
module file_uri_to_path_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tuser,  // [0] has_byte
	output logic       m_axis_tlast
);

	fudec_pkg::q_status_t q_status;
	fudec_pkg::rec_t      push_rec;
	fudec_pkg::rec_t      pop_rec;
	logic                 push;
	logic                 pop;

	// front: prefix match, percent decode, drive letter, builds a record per beat
	fudec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_status (q_status),
		.push     (push),
		.push_rec (push_rec)
	);

	fudec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.pop_rec  (pop_rec),
		.status   (q_status)
	);

	// back: sends the bytes of each record one beat at a time
	fudec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_status (q_status),
		.q_rec    (pop_rec),
		.pop      (pop),
		.tvalid   (m_axis_tvalid),
		.tready   (m_axis_tready),
		.tdata    (m_axis_tdata),
		.tuser    (m_axis_tuser),
		.tlast    (m_axis_tlast)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("record pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("record popped from an empty queue");

	a_bare_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == 8'h00))
		else $error("bare end marker without tlast or with data");

	a_ready_follows_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(!s_axis_tready) |-> q_status.full)
		else $error("input stalled while queue has room");

endmodule

FILE: sim/file_uri_to_path_decoder_unit_test.sv
`timescale 1ns / 1ps

// Bench for the file URI to path decoder.
// A sender task pushes URI bytes into the slave stream. An in-bench predictor
// follows the same rules as the block: prefix match, pass-through, %XX decoding
// and dropping the slash before a drive letter. It queues the path beats that
// each accepted input beat should produce. A checker pops that queue on every
// master-side beat and compares byte, tuser and tlast.
module file_uri_to_path_decoder_unit_test;

	// no accepted beat on either side for this many cycles means the block hung
	localparam int WATCHDOG_LIMIT = 4000;
	// one input beat never yields more than this many path beats
	localparam int RESULTS_PER_BEAT = 8;
	// "file://", index 0 holds 'f'
	localparam logic [6:0][7:0] FILE_PREFIX =
		{8'h2F, 8'h2F, 8'h3A, 8'h65, 8'h6C, 8'h69, 8'h66};

	typedef logic [7:0] uri_t[$];

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} path_beat_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'h00;
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;

	always #2 clk = ~clk;

	file_uri_to_path_decoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// predictor state, mirrors the decoder's registers
	logic [2:0]          pfx_cnt;
	fudec_pkg::mode_t    mode;
	fudec_pkg::esc_t     esc;
	logic [7:0]          esc_first;
	fudec_pkg::drv_t     drv;
	logic [7:0]          held_letter;

	path_beat_t step_beats[$];     // beats caused by the beat being predicted
	path_beat_t path_expected[$];  // beats still owed by the block
	uri_t       rand_uri;

	int idle_pct     = 0;  // share of cycles in which each side holds off
	int errors       = 0;
	int beats_sent   = 0;
	int uris_sent    = 0;
	int results_seen = 0;
	int bare_markers = 0;
	int idle_cycles  = 0;

	task automatic flag_mismatch(input string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// ---------------------------------------------------------------- predictor

	// value of a hex digit, 16 if the char is not one
	function automatic logic [4:0] hex_of(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			return {1'b0, c[3:0]};
		end
		if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			return {1'b0, c[3:0] + 4'd9};
		end
		return 5'd16;
	endfunction

	function automatic logic letter_char(logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic void emit(logic [7:0] b);
		if (step_beats.size() < RESULTS_PER_BEAT) begin
			step_beats.insert(step_beats.size(), {b, 1'b1, 1'b0});
		end
	endfunction

	function automatic void clear_predictor();
		pfx_cnt     = 3'd0;
		mode        = fudec_pkg::MODE_PREFIX;
		esc         = fudec_pkg::ESC_NONE;
		esc_first   = 8'h00;
		drv         = fudec_pkg::DRV_START;
		held_letter = 8'h00;
	endfunction

	// holds back a leading "/X" until it is known whether a colon follows
	function automatic void drive_stage(logic [7:0] b);
		case (drv)
			fudec_pkg::DRV_START: begin
				if (b == fudec_pkg::CH_SLASH) begin
					drv = fudec_pkg::DRV_SLASH;
				end else begin
					emit(b);
					drv = fudec_pkg::DRV_PASS;
				end
			end
			fudec_pkg::DRV_SLASH: begin
				if (letter_char(b)) begin
					held_letter = b;
					drv = fudec_pkg::DRV_LETTER;
				end else begin
					emit(fudec_pkg::CH_SLASH);
					emit(b);
					drv = fudec_pkg::DRV_PASS;
				end
			end
			fudec_pkg::DRV_LETTER: begin
				if (b != fudec_pkg::CH_COLON) begin
					emit(fudec_pkg::CH_SLASH);
				end
				emit(held_letter);
				emit(b);
				drv = fudec_pkg::DRV_PASS;
			end
			default: begin
				emit(b);
			end
		endcase
	endfunction

	function automatic void plain_stage(logic [7:0] b);
		if (b == fudec_pkg::CH_PCT) begin
			esc = fudec_pkg::ESC_PCT;
		end else begin
			drive_stage(b);
		end
	endfunction

	// a broken escape goes out literally and the offending char is fed again
	function automatic void escape_stage(logic [7:0] b);
		logic [4:0] hi;
		logic [4:0] lo;
		hi = hex_of(esc_first);
		lo = hex_of(b);
		case (esc)
			fudec_pkg::ESC_PCT: begin
				if (lo < 5'd16) begin
					esc_first = b;
					esc = fudec_pkg::ESC_HEX;
				end else begin
					drive_stage(fudec_pkg::CH_PCT);
					esc = fudec_pkg::ESC_NONE;
					plain_stage(b);
				end
			end
			fudec_pkg::ESC_HEX: begin
				if (lo < 5'd16) begin
					drive_stage({hi[3:0], lo[3:0]});
					esc = fudec_pkg::ESC_NONE;
				end else begin
					drive_stage(fudec_pkg::CH_PCT);
					drive_stage(esc_first);
					esc = fudec_pkg::ESC_NONE;
					plain_stage(b);
				end
			end
			default: begin
				esc = fudec_pkg::ESC_NONE;
				plain_stage(b);
			end
		endcase
	endfunction

	function automatic void predict_path_bytes(logic [7:0] b, logic last);
		int k;
		step_beats.delete();
		case (mode)
			fudec_pkg::MODE_PREFIX: begin
				if (pfx_cnt < fudec_pkg::PREFIX_LEN && b == FILE_PREFIX[pfx_cnt]) begin
					pfx_cnt = pfx_cnt + 3'd1;
					if (pfx_cnt == fudec_pkg::PREFIX_LEN) begin
						mode = fudec_pkg::MODE_DECODE;
					end else if (last) begin
						// short URI: the partial prefix is plain text after all
						for (k = 0; k < pfx_cnt; k++) begin
							emit(FILE_PREFIX[k]);
						end
					end
				end else begin
					for (k = 0; k < pfx_cnt; k++) begin
						emit(FILE_PREFIX[k]);
					end
					emit(b);
					mode = fudec_pkg::MODE_PASS;
				end
			end
			fudec_pkg::MODE_DECODE: begin
				escape_stage(b);
			end
			default: begin
				emit(b);
			end
		endcase
		if (last) begin
			// end of URI flushes a pending escape, then a held slash or letter
			if (mode == fudec_pkg::MODE_DECODE) begin
				if (esc == fudec_pkg::ESC_PCT) begin
					drive_stage(fudec_pkg::CH_PCT);
				end else if (esc == fudec_pkg::ESC_HEX) begin
					drive_stage(fudec_pkg::CH_PCT);
					drive_stage(esc_first);
				end
				if (drv == fudec_pkg::DRV_SLASH) begin
					emit(fudec_pkg::CH_SLASH);
				end else if (drv == fudec_pkg::DRV_LETTER) begin
					emit(fudec_pkg::CH_SLASH);
					emit(held_letter);
				end
			end
			if (step_beats.size() > 0) begin
				step_beats[step_beats.size() - 1].last = 1'b1;
			end else begin
				// nothing left to carry tlast: bare end marker
				step_beats.insert(0, {8'h00, 1'b0, 1'b1});
			end
			clear_predictor();
		end
		path_expected = {path_expected, step_beats};
	endfunction

	// ---------------------------------------------------------------- stimulus

	// Called at a rising edge. Valid stays high from one beat to the next
	// unless a random gap drops it.
	task automatic send_beat(input logic [7:0] b, input logic last);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predict_path_bytes(b, last);
		beats_sent++;
	endtask

	task automatic send_uri(input uri_t u, input logic close);
		int i;
		for (i = 0; i < u.size(); i++) begin
			send_beat(u[i], close && (i == u.size() - 1));
		end
		if (close) begin
			uris_sent++;
		end
	endtask

	task automatic send_text(input string s, input logic close);
		uri_t q;
		int i;
		for (i = 0; i < s.len(); i++) begin
			q.insert(q.size(), s[i]);
		end
		send_uri(q, close);
	endtask

	// sender holds off until the block has delivered everything owed
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (path_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic logic [7:0] random_letter();
		int n;
		n = $urandom_range(51);
		return (n < 26) ? 8'(8'h41 + n) : 8'(8'h61 + n - 26);
	endfunction

	// skewed toward chars the decoder treats specially
	function automatic logic [7:0] random_path_char();
		logic [7:0] hexdig[22];
		hexdig = '{"0", "1", "2", "3", "4", "5", "6", "7", "8", "9", "a", "b", "c",
			"d", "e", "f", "A", "B", "C", "D", "E", "F"};
		case ($urandom_range(9))
			0, 1:    return fudec_pkg::CH_PCT;
			2, 3:    return hexdig[$urandom_range(21)];
			4:       return fudec_pkg::CH_SLASH;
			5:       return fudec_pkg::CH_COLON;
			6:       return random_letter();
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void build_random_uri();
		int k;
		int n;
		int cut;
		rand_uri.delete();
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				// well-formed file URI with random path, often a drive letter
				for (k = 0; k < 7; k++) begin
					rand_uri.insert(rand_uri.size(), FILE_PREFIX[k]);
				end
				if ($urandom_range(2) == 0) begin
					rand_uri.insert(rand_uri.size(), fudec_pkg::CH_SLASH);
					rand_uri.insert(rand_uri.size(), random_letter());
					rand_uri.insert(rand_uri.size(), ($urandom_range(3) != 0) ?
						fudec_pkg::CH_COLON : random_path_char());
				end
				n = $urandom_range(8);
				repeat (n) rand_uri.insert(rand_uri.size(), random_path_char());
			end
			6, 7: begin
				// prefix cut short, then either the end or one to five random bytes
				cut = $urandom_range(6, 1);
				for (k = 0; k < cut; k++) begin
					rand_uri.insert(rand_uri.size(), FILE_PREFIX[k]);
				end
				if ($urandom_range(1) == 1) begin
					n = $urandom_range(5, 1);
					repeat (n) rand_uri.insert(rand_uri.size(), 8'($urandom_range(255)));
				end
			end
			default: begin
				n = $urandom_range(8, 1);
				repeat (n) rand_uri.insert(rand_uri.size(), 8'($urandom_range(255)));
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_pass_through();
		uri_t q;
		send_text("abc", 1'b1);
		q = '{8'h00, 8'hFF};          // byte extremes, not a file URI
		send_uri(q, 1'b1);
		send_text("fil", 1'b1);       // ends inside the prefix
		send_text("file:/", 1'b1);    // one char short of the prefix
		send_text("file:/x", 1'b1);   // breaks at the last prefix char
	endtask

	task automatic test_bare_prefix();
		send_text("file://", 1'b1);   // empty path: bare end marker
	endtask

	task automatic test_escapes();
		send_text("file://%41%6a%6A%7e", 1'b1);
		send_text("file://%00%ff", 1'b1);
		send_text("file://%g1%4", 1'b1);  // bad first digit, truncated escape
		send_text("file://a%2", 1'b1);
		send_text("file://%", 1'b1);
	endtask

	task automatic test_drive_letter();
		send_text("file:///C:/x", 1'b1);
		send_text("file:///z", 1'b1);     // letter held at the end
		send_text("file:///", 1'b1);      // slash held at the end
		send_text("file:///1", 1'b1);
		send_text("file:///Cx", 1'b1);
		send_text("file://%2Fc%3a", 1'b1); // drive letter spelled as escapes
		send_text("file:///C%4x", 1'b1);   // broken escape behind a held letter
	endtask

	task automatic test_pause_until_drained();
		send_text("file:///D:a", 1'b0);
		wait_drain();
		send_text("%20b", 1'b1);
		wait_drain();
	endtask

	task automatic test_random(input int n_beats, input int pct);
		int target;
		int count;
		target = beats_sent + n_beats;
		count = 0;
		idle_pct = pct;
		while (beats_sent < target) begin
			build_random_uri();
			send_uri(rand_uri, 1'b1);
			count++;
			if (count % 9 == 0) begin
				wait_drain();
			end
		end
	endtask

	// ---------------------------------------------------------------- checker

	always @(posedge clk) begin : path_check
		path_beat_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				if (!m_axis_tuser) begin
					bare_markers++;
				end
				if (path_expected.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat tdata %02h tuser %0b tlast %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast));
				end else begin
					want = path_expected.pop_front();
					if (m_axis_tdata !== want.data) begin
						flag_mismatch($sformatf("beat %0d tdata %02h, want %02h",
							results_seen, m_axis_tdata, want.data));
					end
					if (m_axis_tuser !== want.has) begin
						flag_mismatch($sformatf("beat %0d tuser %0b, want %0b",
							results_seen, m_axis_tuser, want.has));
					end
					if (m_axis_tlast !== want.last) begin
						flag_mismatch($sformatf("beat %0d tlast %0b, want %0b",
							results_seen, m_axis_tlast, want.last));
					end
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= idle_pct);
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		clear_predictor();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part with gaps on both sides
		idle_pct = 26;
		test_pass_through();
		test_bare_prefix();
		test_escapes();
		test_drive_letter();
		test_pause_until_drained();

		// random part: a stretch with no gaps, then the rest with gaps
		test_random(40, 0);
		test_random(35, 26);

		wait_drain();
		// margin for the output register plus the hand-off queue
		repeat (8) @(posedge clk);
		foreach (path_expected[k]) begin
			flag_mismatch($sformatf("missing beat tdata %02h tuser %0b tlast %0b",
				path_expected[k].data, path_expected[k].has, path_expected[k].last));
		end

		$display("covered %0d URIs in %0d input beats; %0d path beats checked, %0d bare ends",
			uris_sent, beats_sent, results_seen, bare_markers);
		$display("pass-through, short prefixes, escapes, drive letters, calm and stalled streams");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

FILE: file_uri_to_path_decoder_unit.f
src/fudec_pkg.sv
src/fudec_front.sv
src/fudec_queue.sv
src/fudec_back.sv
src/file_uri_to_path_decoder_unit.sv
sim/file_uri_to_path_decoder_unit_test.sv
